[rtl/core/spm_pkg.sv]
// shared constants and word types for the stroke point smoother
package spm_pkg;

    // default bound on the smoothing radius
    localparam int SPM_MAX_RADIUS = 5;

    // field widths
    localparam int COORD_W = 20;
    localparam int PRES_W  = 16;
    localparam int CFG_W   = 3;

    // input word: one pen point
    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic        [PRES_W-1:0]  pressure_in;
        logic                      stroke_end;
    } in_word_t;

    // output word: one smoothed point
    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic        [PRES_W-1:0]  pressure_out;
        logic                      stroke_done;
    } out_word_t;

    // one entry of the point history
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [PRES_W-1:0]  p;
    } hist_t;

endpackage

[rtl/core/spm_ram.sv]
// generic single-port-write ram with one registered read port
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/spm_mean_div.sv]
// serial rounded mean: signed window sum divided by point count, ties away from zero
module spm_mean_div import spm_pkg::*; #(
    parameter int SUM_W = 24,
    parameter int CNT_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [SUM_W-1:0]   sum,
    input  logic        [CNT_W-1:0]   cnt,
    output logic                      done,
    output logic signed [COORD_W-1:0] mean
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  work_reg, work_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;

    logic [SUM_W-1:0]   sum_u;
    logic [SUM_W-1:0]   mag;
    logic [SUM_W-1:0]   dvd;
    logic [CNT_W:0]     rem_sh;
    logic [CNT_W:0]     rem_sub;
    logic               ge;
    logic [COORD_W-1:0] q;

    // magnitude plus half the count, for round to nearest
    always_comb
    begin
        sum_u = sum;
        mag   = sum[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;
        dvd   = mag + SUM_W'(cnt[CNT_W-1:1]);
    end

    // one restoring step per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, work_reg[SUM_W-1]};
        ge      = rem_sh >= {1'b0, div_reg};
        rem_sub = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = sum[SUM_W-1];
            work_next = dvd;
            rem_next  = '0;
            div_next  = cnt;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[SUM_W-2:0], ge};
            rem_next  = rem_sub[CNT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    // restore the sign
    always_comb
    begin
        q    = work_reg[COORD_W-1:0];
        mean = neg_reg ? signed'(~q + COORD_W'(1)) : signed'(q);
    end

    assign done = done_reg;

endmodule

[rtl/core/stroke_point_smoother.sv]
// top level of the stroke point smoother: history ram, window sequencer and output register
//
// Input channel in_valid / in_stall / in_data carries one pen point per word, with
// stroke_end on the stroke's last point. Output channel out_valid / out_stall / out_data
// carries smoothed points, oldest first. cfg_we / cfg_wdata set the smoothing radius;
// the radius is latched at the first point of each stroke, values above MAX_RADIUS clamp.
// Each point is written to the history ram in the cycle it is accepted. Results lag the
// input by the radius; the word with stroke_end flushes all pending points (up to
// MAX_RADIUS + 1 results). in_stall is high from acceptance until the last result it
// causes has been taken.
// Per result: the center entry is read (S_CENTER, S_CAP); a smoothed point then sums the
// n-point window through the ram read port (S_SUM, S_LAST) and goes through the serial
// divider (S_DIV; SUM_W = 24 at the default radius), then each result waits in the output
// register (S_OUT). A word that causes no result is taken without leaving S_IDLE; a point
// passed unchanged skips the window sum and the divider.
// While out_stall is high the result holds in the output register and no input is taken.
// Reset clears the radius, the stroke counters and the write pointer; the ram is not
// cleared, since the window never reaches before the first point of a stroke.
module stroke_point_smoother import spm_pkg::*; #(
    parameter int MAX_RADIUS = SPM_MAX_RADIUS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int DEPTH    = 2 * MAX_RADIUS + 1;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int OFF_W    = $clog2(MAX_RADIUS + 2);
    localparam int SEEN_SAT = DEPTH + 1;
    localparam int SEEN_W   = $clog2(SEEN_SAT + 1);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = COORD_W + $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CENTER = 7'b0000010,
        S_CAP    = 7'b0000100,
        S_SUM    = 7'b0001000,
        S_LAST   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  cfg_radius_reg, cfg_radius_next;
    logic [RAD_W-1:0]  radius_reg, radius_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [SEEN_W-1:0] job_seen_reg, job_seen_next;
    logic              job_end_reg, job_end_next;
    logic [PTR_W-1:0]  b_reg, b_next;
    logic [OFF_W-1:0]  rem_reg, rem_next;
    logic [PTR_W-1:0]  k_reg, k_next;
    logic [PTR_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rdv_reg, rdv_next;
    logic signed [SUM_W-1:0] acc_x_reg, acc_x_next;
    logic signed [SUM_W-1:0] acc_y_reg, acc_y_next;
    out_word_t         out_reg, out_next;

    logic              accept;
    logic [RAD_W-1:0]  r_cfg;
    logic [RAD_W-1:0]  r_eff;
    logic [SEEN_W-1:0] seen_inc;
    logic [OFF_W-1:0]  off_inc;
    logic              emit_now;

    logic [SEEN_W-1:0] i_w;
    logic [SEEN_W-1:0] b_w;
    logic [SEEN_W-1:0] r_w;
    logic [SEEN_W-1:0] min_ir;
    logic [SEEN_W-1:0] lo_w;
    logic [SEEN_W-1:0] hi_w;
    logic [SEEN_W-1:0] cnt_w;
    logic              interior;

    logic [PTR_W-1:0]  back_sel;
    logic [PTR_W:0]    slot_sum;
    logic [PTR_W:0]    slot_fix;
    logic [PTR_W-1:0]  rd_addr;
    logic [$bits(hist_t)-1:0] rd_bits;
    hist_t             rd_entry;
    hist_t             wr_entry;

    logic signed [SUM_W-1:0]   add_x;
    logic signed [SUM_W-1:0]   add_y;
    logic                      div_start;
    logic                      div_x_done;
    logic                      div_y_done;
    logic signed [COORD_W-1:0] mean_x;
    logic signed [COORD_W-1:0] mean_y;

    assign accept = in_valid && (state_reg == S_IDLE);

    // stroke bookkeeping for the word being accepted
    always_comb
    begin
        r_cfg    = (int'(cfg_radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                       : RAD_W'(cfg_radius_reg);
        r_eff    = (seen_reg == '0) ? r_cfg : radius_reg;
        seen_inc = (seen_reg < SEEN_W'(SEEN_SAT)) ? (seen_reg + SEEN_W'(1)) : seen_reg;
        off_inc  = offset_reg + OFF_W'(1);
        emit_now = in_data.stroke_end || (SEEN_W'(off_inc) > SEEN_W'(r_eff));
    end

    // window bounds for the point at back offset b
    always_comb
    begin
        b_w      = SEEN_W'(b_reg);
        r_w      = SEEN_W'(radius_reg);
        i_w      = job_seen_reg - SEEN_W'(1) - b_w;
        interior = (i_w != '0) &&
                   (!job_end_reg || ((b_w != '0) && (job_seen_reg >= SEEN_W'(3))));
        min_ir   = (i_w < r_w) ? i_w : r_w;
        lo_w     = b_w + min_ir;
        hi_w     = (b_w > r_w) ? (b_w - r_w) : '0;
        cnt_w    = lo_w - hi_w + SEEN_W'(1);
    end

    // ring slot of a back offset from the newest point
    always_comb
    begin
        back_sel = (state_reg == S_CENTER) ? b_reg : k_reg;
        slot_sum = {1'b0, wp_reg} + (PTR_W + 1)'(DEPTH - 1) - {1'b0, back_sel};
        slot_fix = (slot_sum >= (PTR_W + 1)'(DEPTH)) ? (slot_sum - (PTR_W + 1)'(DEPTH))
                                                     : slot_sum;
        rd_addr  = slot_fix[PTR_W-1:0];
    end

    assign wr_entry.x = in_data.x_in;
    assign wr_entry.y = in_data.y_in;
    assign wr_entry.p = in_data.pressure_in;
    assign rd_entry   = hist_t'(rd_bits);

    // point history
    spm_ram #(
        .WIDTH ($bits(hist_t)),
        .DEPTH (DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_bits)
    );

    // window accumulation
    always_comb
    begin
        add_x = acc_x_reg + SUM_W'(rd_entry.x);
        add_y = acc_y_reg + SUM_W'(rd_entry.y);
    end

    assign div_start = (state_reg == S_LAST);

    spm_mean_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (add_x),
        .cnt   (cnt_reg),
        .done  (div_x_done),
        .mean  (mean_x)
    );

    spm_mean_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (add_y),
        .cnt   (cnt_reg),
        .done  (div_y_done),
        .mean  (mean_y)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cfg_radius_next = cfg_we ? cfg_wdata : cfg_radius_reg;
        radius_next     = radius_reg;
        wp_next         = wp_reg;
        seen_next       = seen_reg;
        offset_next     = offset_reg;
        job_seen_next   = job_seen_reg;
        job_end_next    = job_end_reg;
        b_next          = b_reg;
        rem_next        = rem_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        cnt_next        = cnt_reg;
        rdv_next        = 1'b0;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        out_next        = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    radius_next   = r_eff;
                    wp_next       = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : (wp_reg + PTR_W'(1));
                    job_seen_next = seen_inc;
                    job_end_next  = in_data.stroke_end;
                    if (in_data.stroke_end)
                    begin
                        seen_next   = '0;
                        offset_next = '0;
                        b_next      = PTR_W'(offset_reg);
                        rem_next    = off_inc;
                    end
                    else
                    begin
                        seen_next   = seen_inc;
                        offset_next = emit_now ? OFF_W'(r_eff) : off_inc;
                        b_next      = PTR_W'(r_eff);
                        rem_next    = OFF_W'(1);
                    end
                    if (emit_now)
                    begin
                        state_next = S_CENTER;
                    end
                end
            end
            S_CENTER:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                out_next.pressure_out = rd_entry.p;
                out_next.stroke_done  = job_end_reg && (b_reg == '0);
                k_next                = hi_w[PTR_W-1:0];
                lo_next               = lo_w[PTR_W-1:0];
                cnt_next              = cnt_w[CNT_W-1:0];
                acc_x_next            = '0;
                acc_y_next            = '0;
                if (interior)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    out_next.x_out = rd_entry.x;
                    out_next.y_out = rd_entry.y;
                    state_next     = S_OUT;
                end
            end
            S_SUM:
            begin
                rdv_next = 1'b1;
                if (rdv_reg)
                begin
                    acc_x_next = add_x;
                    acc_y_next = add_y;
                end
                if (k_reg == lo_reg)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    k_next = k_reg + PTR_W'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_x_done && div_y_done)
                begin
                    out_next.x_out = mean_x;
                    out_next.y_out = mean_y;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (rem_reg == OFF_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        b_next     = b_reg - PTR_W'(1);
                        rem_next   = rem_reg - OFF_W'(1);
                        state_next = S_CENTER;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_radius_reg <= '0;
            radius_reg     <= '0;
            wp_reg         <= '0;
            seen_reg       <= '0;
            offset_reg     <= '0;
            job_seen_reg   <= '0;
            job_end_reg    <= 1'b0;
            b_reg          <= '0;
            rem_reg        <= '0;
            k_reg          <= '0;
            lo_reg         <= '0;
            cnt_reg        <= '0;
            rdv_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_radius_reg <= cfg_radius_next;
            radius_reg     <= radius_next;
            wp_reg         <= wp_next;
            seen_reg       <= seen_next;
            offset_reg     <= offset_next;
            job_seen_reg   <= job_seen_next;
            job_end_reg    <= job_end_next;
            b_reg          <= b_next;
            rem_reg        <= rem_next;
            k_reg          <= k_next;
            lo_reg         <= lo_next;
            cnt_reg        <= cnt_next;
            rdv_reg        <= rdv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        out_reg   <= out_next;
    end

    // ports
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// self-checking bench for the stroke point smoother, directed and random pen strokes
module tb import spm_pkg::*; ();

    localparam int HIST_DEPTH = 2 * SPM_MAX_RADIUS + 1;
    localparam int SEEN_CAP   = 255;
    localparam int SETTLE_CYC = 60;
    localparam int COORD_MIN  = -(1 << (COORD_W - 1));
    localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
    localparam int PRES_MAX   = (1 << PRES_W) - 1;
    localparam int PHASES     = 16;
    localparam int PHASE_PTS  = 10;

    // which side idles or stalls
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    // shape of the coordinates along a stroke
    typedef enum int {PATH_RANDOM, PATH_WALK, PATH_EXTREME, PATH_TINY} path_style_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_word_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_word_t        out_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // words waiting to be sent and smoothed points waiting to come out
    in_word_t   point_feed[$];
    out_word_t  due_points[$];

    // shadow of the smoother state
    hist_t      history [HIST_DEPTH];
    int         wr_ptr       = 0;
    int         seen_count   = 0;
    int         unsent_count = 0;
    int         radius_reg   = 0;
    int         stroke_rad   = 0;

    logic       word_taken   = 1'b0;
    idle_mode_t idle_mode    = IDLE_NONE;
    int         error_count  = 0;

    stroke_point_smoother uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic note_bad_point(input string why);
        error_count++;
        if (error_count <= 40)
            $display("%0t ns: mismatch: %s", $time, why);
    endtask

    // history slot of the point `back` positions before the newest one
    function automatic int slot_back(input int back);
        return (wr_ptr + 2 * HIST_DEPTH - 1 - back) % HIST_DEPTH;
    endfunction

    // mean rounded to nearest, ties away from zero
    function automatic longint round_avg(input longint total, input longint n);
        longint mag;
        mag = (total < 0) ? -total : total;
        mag = (mag + n / 2) / n;
        return (total < 0) ? -mag : mag;
    endfunction

    // build the output word for the point at `back`, averaged over near_back..far_back
    function automatic out_word_t windowed_point(input int back, input bit smooth,
                                                 input int far_back, input int near_back,
                                                 input bit is_tail);
        out_word_t pt;
        hist_t     ctr;
        hist_t     nb;
        longint    sx;
        longint    sy;
        int        k;
        ctr = history[slot_back(back)];
        pt.x_out        = ctr.x;
        pt.y_out        = ctr.y;
        pt.pressure_out = ctr.p;
        pt.stroke_done  = is_tail;
        if (smooth)
        begin
            sx = 0;
            sy = 0;
            for (k = near_back; k <= far_back; k++)
            begin
                nb = history[slot_back(k)];
                sx += nb.x;
                sy += nb.y;
            end
            pt.x_out = COORD_W'(round_avg(sx, far_back - near_back + 1));
            pt.y_out = COORD_W'(round_avg(sy, far_back - near_back + 1));
        end
        return pt;
    endfunction

    // take one accepted point and queue the smoothed points it releases
    function automatic void advance_stroke(input in_word_t w);
        int r;
        int i;
        int b;
        int far_b;
        int near_b;
        bit smooth;
        if (seen_count == 0)
            stroke_rad = (radius_reg > SPM_MAX_RADIUS) ? SPM_MAX_RADIUS : radius_reg;
        r = stroke_rad;
        history[wr_ptr].x = w.x_in;
        history[wr_ptr].y = w.y_in;
        history[wr_ptr].p = w.pressure_in;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (seen_count < SEEN_CAP)
            seen_count++;
        unsent_count++;
        if (!w.stroke_end)
        begin
            // steady state: the point r behind the newest comes out
            if (unsent_count > r)
            begin
                i = seen_count - 1 - r;
                due_points = {due_points,
                              windowed_point(r, i != 0, r + ((i < r) ? i : r), 0, 1'b0)};
                unsent_count = r;
            end
        end
        else
        begin
            // flush every pending point, oldest first
            for (b = unsent_count - 1; b >= 0; b--)
            begin
                i      = seen_count - 1 - b;
                smooth = (i != 0) && (b != 0) && (seen_count >= 3);
                far_b  = b + ((i < r) ? i : r);
                near_b = (b > r) ? b - r : 0;
                due_points = {due_points, windowed_point(b, smooth, far_b, near_b, b == 0)};
            end
            seen_count   = 0;
            unsent_count = 0;
        end
    endfunction

    // point driver: a new word goes out only once the current one has been taken
    always @(negedge clk)
    begin : drive_points
        int gap_pct;
        int stall_pct;
        gap_pct   = (idle_mode == IDLE_SENDER) ? 51 : (idle_mode == IDLE_BOTH) ? 32 : 0;
        stall_pct = (idle_mode == IDLE_RECEIVER) ? 51 : (idle_mode == IDLE_BOTH) ? 32 : 0;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && (!in_valid || word_taken))
        begin
            if (point_feed.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                in_data  <= point_feed.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: track config and accepted words, check each smoothed word taken
    always @(posedge clk)
    begin : watch_points
        out_word_t want;
        word_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_we)
                radius_reg = cfg_wdata;
            if (in_valid && !in_stall)
                advance_stroke(in_data);
            if (out_valid && !out_stall)
            begin
                if (due_points.size() == 0)
                begin
                    note_bad_point($sformatf("unexpected word x=%0d y=%0d p=%0d done=%0b",
                                             out_data.x_out, out_data.y_out,
                                             out_data.pressure_out, out_data.stroke_done));
                end
                else
                begin
                    want = due_points.pop_front();
                    if (out_data.x_out !== want.x_out)
                        note_bad_point($sformatf("x_out %0d, want %0d",
                                                 out_data.x_out, want.x_out));
                    if (out_data.y_out !== want.y_out)
                        note_bad_point($sformatf("y_out %0d, want %0d",
                                                 out_data.y_out, want.y_out));
                    if (out_data.pressure_out !== want.pressure_out)
                        note_bad_point($sformatf("pressure_out %0d, want %0d",
                                                 out_data.pressure_out, want.pressure_out));
                    if (out_data.stroke_done !== want.stroke_done)
                        note_bad_point($sformatf("stroke_done %0b, want %0b",
                                                 out_data.stroke_done, want.stroke_done));
                end
            end
        end
    end

    function automatic int any_coord();
        return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
    endfunction

    task automatic queue_point(input int x, input int y, input int p, input bit is_tail);
        in_word_t w;
        w.x_in        = COORD_W'(x);
        w.y_in        = COORD_W'(y);
        w.pressure_in = PRES_W'(p);
        w.stroke_end  = is_tail;
        point_feed = {point_feed, w};
    endtask

    // one stroke of len points; an open stroke gets no end flag
    task automatic queue_stroke(input int len, input path_style_t style, input bit leave_open);
        int x;
        int y;
        int p;
        int k;
        x = any_coord();
        y = any_coord();
        for (k = 0; k < len; k++)
        begin
            p = $urandom_range(PRES_MAX);
            case (style)
                PATH_RANDOM:
                begin
                    x = any_coord();
                    y = any_coord();
                end
                PATH_WALK:
                begin
                    x = clamp_coord(x + int'($urandom_range(64)) - 32);
                    y = clamp_coord(y + int'($urandom_range(64)) - 32);
                end
                PATH_EXTREME:
                begin
                    x = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                    y = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                    p = $urandom_range(1) ? PRES_MAX : 0;
                end
                default:
                begin
                    x = int'($urandom_range(6)) - 3;
                    y = int'($urandom_range(6)) - 3;
                end
            endcase
            queue_point(x, y, p, (k == len - 1) && !leave_open);
        end
    endtask

    // wait until every word is sent and every smoothed word has come back
    task automatic wait_quiet();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (point_feed.size() != 0 || in_valid || due_points.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_radius(input int v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        int ph;
        int k;
        int budget;
        int len;
        int pick;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset radius passes points through; field extremes
        queue_point(COORD_MIN, COORD_MAX, PRES_MAX, 1'b0);
        queue_point(COORD_MAX, COORD_MIN, 0, 1'b1);

        // radius above the bound clamps; one-point, two-point and seven-point strokes
        wait_quiet();
        set_radius(7);
        queue_point(-5, 77, 1234, 1'b1);
        queue_point(COORD_MAX, COORD_MAX, 1, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, PRES_MAX - 1, 1'b1);
        for (k = 0; k < 7; k++)
            queue_point((k % 2) ? COORD_MIN : COORD_MAX, (k % 2) ? COORD_MAX : COORD_MIN,
                        k * 9000, k == 6);

        // truncated window with halfway sums, rounding away from zero both signs
        wait_quiet();
        set_radius(2);
        queue_point(1, -1, 10, 1'b0);
        queue_point(1, -1, 20, 1'b0);
        queue_point(0, 0, 30, 1'b0);
        queue_point(0, 0, 40, 1'b0);
        queue_point(0, 0, 50, 1'b1);

        // radius written mid-stroke only applies to the next stroke
        wait_quiet();
        set_radius(3);
        queue_stroke(2, PATH_WALK, 1'b1);
        wait_quiet();
        set_radius(0);
        queue_stroke(4, PATH_WALK, 1'b0);

        // random strokes, a new radius and idling mode per phase
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            set_radius((ph * 3) % 8);
            idle_mode = idle_mode_t'(ph % 4);
            budget = 0;
            while (budget < PHASE_PTS)
            begin
                pick = $urandom_range(19);
                if (pick < 3)
                    len = $urandom_range(2, 1);
                else if (pick < 14)
                    len = $urandom_range(8, 3);
                else if (pick < 18)
                    len = $urandom_range(14, 9);
                else
                    len = $urandom_range(40, 15);
                budget += len;
                queue_stroke(len, path_style_t'($urandom_range(3)),
                             budget >= PHASE_PTS && $urandom_range(3) == 0);
            end
        end

        wait_quiet();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard
    initial
    begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
